### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the clock core; each macro expands to one
// labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/bcdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdc_pkg
// Types, codes and helpers for the BCD time-of-day clock with alarm.
// ----------------------------------------------------------------------------
package bcdc_pkg;

  localparam int DIGIT_W        = 4;
  localparam int NUM_DIGITS     = 6;
  localparam int TICK_LIMIT_W   = 24;
  localparam int PRESCALE_BITS  = 24;

  localparam logic [TICK_LIMIT_W-1:0] TICK_LIMIT_RST = 24'd999;

  // digit order: hour tens, hour units, minute tens, minute units,
  // second tens, second units
  localparam int HT = 0;
  localparam int HU = 1;
  localparam int MT = 2;
  localparam int MU = 3;
  localparam int ST = 4;
  localparam int SU = 5;

  localparam logic [DIGIT_W-1:0] UNSET_DIGIT = 4'hF;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX [NUM_DIGITS] =
    '{4'd2, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9};
  // hour units stop at 3 once hour tens reaches 2
  localparam logic [DIGIT_W-1:0] HOUR_TENS_LAST  = 4'd2;
  localparam logic [DIGIT_W-1:0] HOUR_UNITS_LAST = 4'd3;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET_TIME  = 3'd1;
  localparam logic [2:0] OP_SET_ALARM = 3'd2;
  localparam logic [2:0] OP_SET_STATE = 3'd3;
  localparam logic [2:0] OP_SILENCE   = 3'd4;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_READY   = 2'd1;
  localparam logic [1:0] MODE_RINGING = 2'd2;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;
  typedef logic [3:0][DIGIT_W-1:0]            hhmm_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] hour_tens_in;
    logic [3:0] hour_units_in;
    logic [3:0] minute_tens_in;
    logic [3:0] minute_units_in;
    logic [3:0] second_tens_in;
    logic [3:0] second_units_in;
    logic [1:0] requested_state;
  } in_beat_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] hour_tens_out;
    logic [3:0] hour_units_out;
    logic [3:0] minute_tens_out;
    logic [3:0] minute_units_out;
    logic [3:0] second_tens_out;
    logic [3:0] second_units_out;
    logic       time_valid;
    logic [1:0] alarm_state_out;
    logic       alarm_drive;
  } out_beat_t;

  typedef struct packed {
    logic               load;
    logic [DIGIT_W-1:0] load_val;
    logic [DIGIT_W-1:0] max_val;
  } cell_ctl_t;

  typedef struct packed {
    logic       set_alarm;
    logic       set_mode;
    logic       silence;
    logic       minute_roll;
    logic [1:0] req_mode;
    hhmm_t      alarm_val;
    hhmm_t      hhmm_nxt;
  } alarm_ctl_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       level;
    logic [1:0] mode_nxt;
    logic       level_nxt;
  } alarm_sts_t;

  function automatic logic digits_valid(input digits_t d);
    logic hours;
    logic mins;
    logic secs;
    hours = (d[HT] <= 4'd2) && (d[HU] <= 4'd9) && ((d[HT] < 4'd2) || (d[HU] <= 4'd3));
    mins  = (d[MT] < 4'd6) && (d[MU] < 4'd10);
    secs  = (d[ST] < 4'd6) && (d[SU] < 4'd10);
    return hours && mins && secs;
  endfunction

endpackage

### rtl/core/bcdc_digit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdc_digit_cell
// One BCD digit of the time chain: loads, or counts on carry-in and hands
// a carry to the next more significant digit when it wraps.
// ----------------------------------------------------------------------------
module bcdc_digit_cell #(
  parameter logic [bcdc_pkg::DIGIT_W-1:0] RST_VAL = '0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bcdc_pkg::cell_ctl_t              ctl,
  input  logic                             carry_in,
  output logic                             carry_out,
  output logic [bcdc_pkg::DIGIT_W-1:0]     digit,
  output logic [bcdc_pkg::DIGIT_W-1:0]     digit_nxt
);

  logic [bcdc_pkg::DIGIT_W-1:0] digit_r;
  logic                         at_max;

  assign at_max    = (digit_r == ctl.max_val);
  assign carry_out = carry_in && at_max;

  always_comb begin
    if (ctl.load) begin
      digit_nxt = ctl.load_val;
    end else if (carry_in) begin
      digit_nxt = at_max ? '0 : digit_r + bcdc_pkg::DIGIT_W'(1);
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= RST_VAL;
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

### rtl/core/bcdc_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdc_alarm
// Alarm hh:mm store, alarm mode and drive level; matches on minute rollover.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcdc_alarm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcdc_pkg::alarm_ctl_t ctl,
  output bcdc_pkg::alarm_sts_t sts
);

  bcdc_pkg::hhmm_t alarm_r;
  bcdc_pkg::hhmm_t alarm_nxt;
  logic [1:0]      mode_r;
  logic [1:0]      mode_nxt;
  logic            level_r;
  logic            level_nxt;
  logic            hit;

  assign hit = ctl.minute_roll && (mode_r == bcdc_pkg::MODE_READY) &&
               (alarm_r == ctl.hhmm_nxt);

  always_comb begin
    alarm_nxt = alarm_r;
    mode_nxt  = mode_r;
    level_nxt = level_r;
    if (hit) begin
      mode_nxt  = bcdc_pkg::MODE_RINGING;
      level_nxt = 1'b1;
    end
    if (ctl.set_alarm) begin
      alarm_nxt = ctl.alarm_val;
      mode_nxt  = bcdc_pkg::MODE_READY;
    end
    if (ctl.set_mode) begin
      mode_nxt = ctl.req_mode;
    end
    if (ctl.silence) begin
      mode_nxt  = bcdc_pkg::MODE_READY;
      level_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r <= '0;
      mode_r  <= bcdc_pkg::MODE_OFF;
      level_r <= 1'b0;
    end else begin
      alarm_r <= alarm_nxt;
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
    end
  end

  assign sts.mode      = mode_r;
  assign sts.level     = level_r;
  assign sts.mode_nxt  = mode_nxt;
  assign sts.level_nxt = level_nxt;

  // the drive only comes up through a match, which also starts ringing
  `ASSERT_CLK(a_drive_rise_rings, clk, rst_n,
    $rose(level_r) |-> (mode_r == bcdc_pkg::MODE_RINGING), "drive rose without ringing")

endmodule

### rtl/core/bcd_clock_with_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_clock_with_alarm
// 24-hour BCD time-of-day clock with tick prescaler and hh:mm alarm.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake         | beat
//   ---------+-----------+-------------------+------------------------------
//   in_      | input     | in_valid/in_stall | one operation (in_beat_t)
//   out_     | output    | out_valid/stall   | one result (out_beat_t)
//   cfg_     | input     | cfg_valid/ready   | tick_limit write data
//
// Each operation is handled as a single beat; one beat is taken each clock while the
// result register is free or being drained. Six digit cells pass the carry
// in the same cycle, so a tick and its rollover land together.
// The result register stalls the input only while it is full and stalled.
// Synchronous reset, no clearing pass; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcd_clock_with_alarm #(
  parameter int PRESCALE_BITS = bcdc_pkg::PRESCALE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bcdc_pkg::in_beat_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bcdc_pkg::out_beat_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcdc_pkg::TICK_LIMIT_W-1:0]  cfg_data
);

  localparam int CMP_W = (PRESCALE_BITS > bcdc_pkg::TICK_LIMIT_W) ?
                         PRESCALE_BITS : bcdc_pkg::TICK_LIMIT_W;

  logic [bcdc_pkg::TICK_LIMIT_W-1:0] tick_limit_r;
  logic [PRESCALE_BITS-1:0]          prescale_r;
  logic [PRESCALE_BITS-1:0]          prescale_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  bcdc_pkg::out_beat_t               out_data_r;
  bcdc_pkg::out_beat_t               out_data_nxt;

  logic                              in_acc;
  logic                              is_tick;
  logic                              roll;
  logic                              unset;
  logic                              acc;
  logic                              advance;
  logic                              load_time;
  bcdc_pkg::digits_t                 in_dig;
  bcdc_pkg::digits_t                 dig_q;
  bcdc_pkg::digits_t                 dig_nxt;
  logic [bcdc_pkg::NUM_DIGITS:0]     carry;
  bcdc_pkg::cell_ctl_t               cell_ctl [bcdc_pkg::NUM_DIGITS];
  bcdc_pkg::alarm_ctl_t              alarm_ctl;
  bcdc_pkg::alarm_sts_t              alarm_sts;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign in_dig[bcdc_pkg::HT] = in_data.hour_tens_in;
  assign in_dig[bcdc_pkg::HU] = in_data.hour_units_in;
  assign in_dig[bcdc_pkg::MT] = in_data.minute_tens_in;
  assign in_dig[bcdc_pkg::MU] = in_data.minute_units_in;
  assign in_dig[bcdc_pkg::ST] = in_data.second_tens_in;
  assign in_dig[bcdc_pkg::SU] = in_data.second_units_in;

  assign unset   = (dig_q[bcdc_pkg::HT] == bcdc_pkg::UNSET_DIGIT);
  assign is_tick = (in_data.operation == bcdc_pkg::OP_TICK);
  assign roll    = (CMP_W'(prescale_r) >= CMP_W'(tick_limit_r));

  always_comb begin
    case (in_data.operation)
      bcdc_pkg::OP_TICK:      acc = 1'b1;
      bcdc_pkg::OP_SET_TIME:  acc = bcdc_pkg::digits_valid(in_dig);
      bcdc_pkg::OP_SET_ALARM: acc = !unset;
      bcdc_pkg::OP_SET_STATE: acc = (in_data.requested_state <= bcdc_pkg::MODE_RINGING) &&
                                    !unset &&
                                    !((alarm_sts.mode != bcdc_pkg::MODE_READY) &&
                                      (in_data.requested_state == bcdc_pkg::MODE_OFF));
      bcdc_pkg::OP_SILENCE:   acc = 1'b1;
      default:                acc = 1'b0;
    endcase
  end

  assign advance   = in_acc && is_tick && roll && !unset;
  assign load_time = in_acc && (in_data.operation == bcdc_pkg::OP_SET_TIME) && acc;

  // prescaler keeps running while the time is unset
  always_comb begin
    prescale_nxt = prescale_r;
    if (in_acc && is_tick) begin
      prescale_nxt = roll ? '0 : prescale_r + PRESCALE_BITS'(1);
    end
  end

  // digit chain, carry enters at second units
  assign carry[bcdc_pkg::NUM_DIGITS] = advance;

  for (genvar i = 0; i < bcdc_pkg::NUM_DIGITS; i++) begin : g_cell
    assign cell_ctl[i].load     = load_time;
    assign cell_ctl[i].load_val = in_dig[i];
    if (i == bcdc_pkg::HU) begin : g_hu
      assign cell_ctl[i].max_val = (dig_q[bcdc_pkg::HT] == bcdc_pkg::HOUR_TENS_LAST) ?
                                   bcdc_pkg::HOUR_UNITS_LAST : bcdc_pkg::DIGIT_MAX[i];
    end else begin : g_fixed
      assign cell_ctl[i].max_val = bcdc_pkg::DIGIT_MAX[i];
    end

    bcdc_digit_cell #(
      .RST_VAL ((i == bcdc_pkg::HT) ? bcdc_pkg::UNSET_DIGIT : 4'd0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl[i]),
      .carry_in  (carry[i+1]),
      .carry_out (carry[i]),
      .digit     (dig_q[i]),
      .digit_nxt (dig_nxt[i])
    );
  end

  // carry out of second tens marks a minute rollover
  assign alarm_ctl.set_alarm   = in_acc && (in_data.operation == bcdc_pkg::OP_SET_ALARM) && acc;
  assign alarm_ctl.set_mode    = in_acc && (in_data.operation == bcdc_pkg::OP_SET_STATE) && acc;
  assign alarm_ctl.silence     = in_acc && (in_data.operation == bcdc_pkg::OP_SILENCE);
  assign alarm_ctl.minute_roll = carry[bcdc_pkg::ST];
  assign alarm_ctl.req_mode    = in_data.requested_state;
  assign alarm_ctl.alarm_val   = {in_dig[bcdc_pkg::HT], in_dig[bcdc_pkg::HU],
                                  in_dig[bcdc_pkg::MT], in_dig[bcdc_pkg::MU]};
  assign alarm_ctl.hhmm_nxt    = {dig_nxt[bcdc_pkg::HT], dig_nxt[bcdc_pkg::HU],
                                  dig_nxt[bcdc_pkg::MT], dig_nxt[bcdc_pkg::MU]};

  bcdc_alarm u_alarm (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alarm_ctl),
    .sts   (alarm_sts)
  );

  always_comb begin
    out_data_nxt.accepted         = acc;
    out_data_nxt.hour_tens_out    = dig_nxt[bcdc_pkg::HT];
    out_data_nxt.hour_units_out   = dig_nxt[bcdc_pkg::HU];
    out_data_nxt.minute_tens_out  = dig_nxt[bcdc_pkg::MT];
    out_data_nxt.minute_units_out = dig_nxt[bcdc_pkg::MU];
    out_data_nxt.second_tens_out  = dig_nxt[bcdc_pkg::ST];
    out_data_nxt.second_units_out = dig_nxt[bcdc_pkg::SU];
    out_data_nxt.time_valid       = bcdc_pkg::digits_valid(dig_nxt);
    out_data_nxt.alarm_state_out  = alarm_sts.mode_nxt;
    out_data_nxt.alarm_drive      = alarm_sts.level_nxt;
  end

  assign out_valid_nxt = in_acc ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_limit_r <= bcdc_pkg::TICK_LIMIT_RST;
      prescale_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tick_limit_r <= cfg_data;
      end
      prescale_r  <= prescale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_set_time_valid, clk, rst_n,
    rst_n && load_time, out_data.time_valid && out_data.accepted,
    "accepted time set left an invalid time")

  `ASSERT_NEXT(a_digits_hold, clk, rst_n,
    rst_n && !in_acc, $stable(dig_q), "time digits moved without a beat")

  `ASSERT_CLK(a_hour_tens_range, clk, rst_n,
    (dig_q[bcdc_pkg::HT] == bcdc_pkg::UNSET_DIGIT) ||
    (dig_q[bcdc_pkg::HT] <= bcdc_pkg::HOUR_TENS_LAST), "hour tens out of range")

endmodule

### tb/tb_bcd_clock_with_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bcd_clock_with_alarm
// Self-checking bench for the BCD time-of-day clock with alarm. A queue of
// operations feeds a clocked driver; every accepted operation is run through
// a behavioral clock model and the predicted result is compared field by
// field with each result beat. Random gaps and stalls on both channels, one
// long output hold, and several tick_limit settings written between phases.
// ----------------------------------------------------------------------------
module tb_bcd_clock_with_alarm;
  import bcdc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int PRESSURE_AT    = 200;
  localparam int PRESSURE_LEN   = 64;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [1:0] REQ_RSVD   = 2'd3;
  localparam logic [TICK_LIMIT_W-1:0] TICK_LIMIT_MAX = 24'hFFFFFF;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_beat_t                in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_beat_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [TICK_LIMIT_W-1:0] cfg_data = '0;

  // clock model state
  logic [TICK_LIMIT_W-1:0]  tick_limit_q;
  digits_t                  clk_dig;
  hhmm_t                    alm_dig;
  logic [1:0]               alm_mode;
  logic [PRESCALE_BITS-1:0] presc_cnt;
  logic                     alm_level;

  in_beat_t  pending_ops[$];
  out_beat_t expected_results[$];
  out_beat_t oldest_expected;

  int drv_gap = 0;
  int drv_calm = 0;
  int mon_calm = 0;
  int mon_pause;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;

  bcd_clock_with_alarm uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("tb_bcd_clock_with_alarm NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic bit time_ok(input digits_t d);
    return d[HU] <= 4'd9 && d[MU] <= 4'd9 && d[SU] <= 4'd9 &&
           d[MT] <= 4'd5 && d[ST] <= 4'd5 &&
           (int'(d[HT]) * 10 + int'(d[HU])) < 24;
  endfunction

  function automatic void next_second();
    if (clk_dig[HT] == UNSET_DIGIT) return;
    if (clk_dig[SU] < 4'd9) begin
      clk_dig[SU] = clk_dig[SU] + 4'd1;
    end else begin
      clk_dig[SU] = 4'd0;
      if (clk_dig[ST] < 4'd5) begin
        clk_dig[ST] = clk_dig[ST] + 4'd1;
      end else begin
        clk_dig[ST] = 4'd0;
        if (clk_dig[MU] < 4'd9) begin
          clk_dig[MU] = clk_dig[MU] + 4'd1;
        end else begin
          clk_dig[MU] = 4'd0;
          if (clk_dig[MT] < 4'd5) begin
            clk_dig[MT] = clk_dig[MT] + 4'd1;
          end else begin
            clk_dig[MT] = 4'd0;
            if (clk_dig[HT] == 4'd2 ? clk_dig[HU] < 4'd3 : clk_dig[HU] < 4'd9) begin
              clk_dig[HU] = clk_dig[HU] + 4'd1;
            end else begin
              clk_dig[HU] = 4'd0;
              clk_dig[HT] = (clk_dig[HT] < 4'd2) ? clk_dig[HT] + 4'd1 : 4'd0;
            end
          end
        end
        // alarm is compared on minute rollover only
        if (alm_mode == MODE_READY && alm_dig == clk_dig[MU:HT]) begin
          alm_mode  = MODE_RINGING;
          alm_level = 1'b1;
        end
      end
    end
  endfunction

  function automatic out_beat_t clock_predict(input in_beat_t b);
    out_beat_t r;
    digits_t   d;
    logic      unset;
    logic      ok;
    d = {b.second_units_in, b.second_tens_in, b.minute_units_in,
         b.minute_tens_in, b.hour_units_in, b.hour_tens_in};
    unset = (clk_dig[HT] == UNSET_DIGIT);
    ok = 1'b0;
    case (b.operation)
      OP_TICK: begin
        if (presc_cnt >= tick_limit_q) begin
          presc_cnt = '0;
          next_second();
        end else begin
          presc_cnt = presc_cnt + 1'b1;
        end
        ok = 1'b1;
      end
      OP_SET_TIME: begin
        if (time_ok(d)) begin
          clk_dig = d;
          ok = 1'b1;
        end
      end
      OP_SET_ALARM: begin
        if (!unset) begin
          alm_dig  = d[MU:HT];
          alm_mode = MODE_READY;
          ok = 1'b1;
        end
      end
      OP_SET_STATE: begin
        if (b.requested_state != REQ_RSVD && !unset &&
            !(alm_mode != MODE_READY && b.requested_state == MODE_OFF)) begin
          alm_mode = b.requested_state;
          ok = 1'b1;
        end
      end
      OP_SILENCE: begin
        alm_level = 1'b0;
        alm_mode  = MODE_READY;
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    r.accepted         = ok;
    r.hour_tens_out    = clk_dig[HT];
    r.hour_units_out   = clk_dig[HU];
    r.minute_tens_out  = clk_dig[MT];
    r.minute_units_out = clk_dig[MU];
    r.second_tens_out  = clk_dig[ST];
    r.second_units_out = clk_dig[SU];
    r.time_valid       = time_ok(clk_dig);
    r.alarm_state_out  = alm_mode;
    r.alarm_drive      = alm_level;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_beat_t noise_beat();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  task automatic queue_op(input logic [2:0] op, input int ht, hu, mt, mu, st, su,
                          input logic [1:0] req);
    in_beat_t b;
    b.operation       = op;
    b.hour_tens_in    = 4'(ht);
    b.hour_units_in   = 4'(hu);
    b.minute_tens_in  = 4'(mt);
    b.minute_units_in = 4'(mu);
    b.second_tens_in  = 4'(st);
    b.second_units_in = 4'(su);
    b.requested_state = req;
    pending_ops.push_back(b);
  endtask

  task automatic queue_tick();
    in_beat_t b;
    b = noise_beat();
    b.operation = OP_TICK;
    pending_ops.push_back(b);
  endtask

  // set a time just before a minute rollover, arm the alarm, tick through it
  task automatic queue_alarm_run(input int lim);
    int hh, mm, su, ah, am, k, n;
    hh = ($urandom_range(0, 4) == 0) ? 23 : $urandom_range(0, 23);
    mm = ($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 59);
    su = $urandom_range(0, 9);
    queue_op(OP_SET_TIME, hh / 10, hh % 10, mm / 10, mm % 10, 5, su,
             2'($urandom_range(0, 3)));
    am = mm + 1;
    ah = hh;
    if (am == 60) begin
      am = 0;
      ah = (ah + 1) % 24;
    end
    k = $urandom_range(0, 9);
    if (k >= 7) begin
      ah = $urandom_range(0, 23);
      am = $urandom_range(0, 59);
    end
    if (k == 9) begin
      queue_op(OP_SET_ALARM, $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 15), 2'($urandom_range(0, 3)));
    end else begin
      queue_op(OP_SET_ALARM, ah / 10, ah % 10, am / 10, am % 10, $urandom_range(0, 15),
               $urandom_range(0, 15), 2'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 4) == 0)
      queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, 2'($urandom_range(0, 3)));
    n = (10 - su) * (lim + 1) + $urandom_range(0, 2 * lim + 1);
    repeat (n) begin
      if ($urandom_range(0, 24) == 0) pending_ops.push_back(noise_beat());
      else queue_tick();
    end
  endtask

  task automatic queue_random(input int count);
    int target, r;
    target = pending_ops.size() + count;
    while (pending_ops.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 60 && tick_limit_q <= 3) begin
        queue_alarm_run(int'(tick_limit_q));
      end else if (r < 80) begin
        pending_ops.push_back(noise_beat());
      end else begin
        repeat ($urandom_range(1, 20)) queue_tick();
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || out_valid || expected_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_tick_limit(input logic [TICK_LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid    <= 1'b0;
    tick_limit_q = value;
    @(negedge clk);
  endtask

  initial begin
    tick_limit_q = TICK_LIMIT_RST;
    clk_dig      = '0;
    clk_dig[HT]  = UNSET_DIGIT;
    alm_dig      = '0;
    alm_mode     = MODE_OFF;
    presc_cnt    = '0;
    alm_level    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // time unset: prescaler runs, alarm changes refused, silence still taken
    queue_op(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_ALARM, 1, 2, 3, 4, 0, 0, MODE_OFF);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_READY);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SILENCE, 15, 15, 15, 15, 15, 15, REQ_RSVD);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_RINGING);
    queue_op(OP_RSVD_HI, 1, 2, 3, 4, 5, 6, MODE_READY);
    // bad time sets
    queue_op(OP_SET_TIME, 2, 4, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 2, 9, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 0, 15, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 0, 0, 6, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 0, 0, 0, 10, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 0, 0, 0, 0, 6, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 0, 0, 0, 0, 0, 15, MODE_OFF);
    // extremes of a good time
    queue_op(OP_SET_TIME, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 2, 3, 5, 9, 5, 9, MODE_OFF);
    queue_op(OP_SET_ALARM, 0, 0, 0, 0, 15, 15, MODE_OFF);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, REQ_RSVD);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_OFF);
    // ringing by request leaves the drive low
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_RINGING);
    queue_op(OP_SILENCE, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_ALARM, 15, 15, 15, 15, 0, 0, MODE_OFF);
    queue_op(OP_RSVD_LO, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_ALARM, 0, 0, 0, 0, 0, 0, MODE_OFF);
    wait_idle();

    write_tick_limit('0);
    // midnight rollover rings the alarm
    queue_op(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_READY);
    queue_op(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SILENCE, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 0, 9, 5, 9, 5, 9, MODE_OFF);
    queue_op(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_OFF);
    // alarm not ready on the rollover: no match
    queue_op(OP_SET_ALARM, 1, 2, 3, 5, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 1, 2, 3, 4, 5, 9, MODE_OFF);
    queue_op(OP_SET_STATE, 0, 0, 0, 0, 0, 0, MODE_RINGING);
    queue_op(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_op(OP_SET_ALARM, 1, 2, 3, 6, 0, 0, MODE_OFF);
    queue_op(OP_SET_TIME, 1, 2, 3, 5, 5, 9, MODE_OFF);
    queue_op(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_OFF);
    queue_random(250);
    wait_idle();

    write_tick_limit(24'd1);
    queue_random(150);
    wait_idle();

    write_tick_limit(TICK_LIMIT_MAX);
    queue_random(60);
    wait_idle();

    write_tick_limit(24'd3);
    queue_random(150);
    wait_idle();

    write_tick_limit(TICK_LIMIT_RST);
    queue_random(60);
    wait_idle();

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_bcd_clock_with_alarm OK");
    end else begin
      $display("tb_bcd_clock_with_alarm NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(clock_predict(in_data));
      if (in_valid && in_stall) begin
        // stalled beat holds
      end else if (drv_gap > 0) begin
        drv_gap  <= drv_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_data  <= pending_ops.pop_front();
        in_valid <= 1'b1;
        drv_gap  <= pause_len(drv_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("accepted", 4'(oldest_expected.accepted), 4'(out_data.accepted));
        check_field("hour_tens_out", oldest_expected.hour_tens_out, out_data.hour_tens_out);
        check_field("hour_units_out", oldest_expected.hour_units_out, out_data.hour_units_out);
        check_field("minute_tens_out", oldest_expected.minute_tens_out,
                    out_data.minute_tens_out);
        check_field("minute_units_out", oldest_expected.minute_units_out,
                    out_data.minute_units_out);
        check_field("second_tens_out", oldest_expected.second_tens_out,
                    out_data.second_tens_out);
        check_field("second_units_out", oldest_expected.second_units_out,
                    out_data.second_units_out);
        check_field("time_valid", 4'(oldest_expected.time_valid), 4'(out_data.time_valid));
        check_field("alarm_state_out", 4'(oldest_expected.alarm_state_out),
                    4'(out_data.alarm_state_out));
        check_field("alarm_drive", 4'(oldest_expected.alarm_drive),
                    4'(out_data.alarm_drive));
      end
      results_seen <= results_seen + 1;
    end
  end

  // result side stalls; one long hold lets the block fill and stall its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
      pressure_done <= 1'b1;
      out_stall     <= 1'b1;
      hold_left     <= PRESSURE_LEN - 1;
    end else begin
      mon_pause = pause_len(mon_calm);
      out_stall <= (mon_pause > 0);
      hold_left <= (mon_pause > 0) ? mon_pause - 1 : 0;
    end
  end

endmodule
